// ===== rtl/tfp_pkg.sv =====
// Shared constants and types for the telemetry frame parser.
package tfp_pkg;

    // Payload store sizing: an 'M' frame never holds more than 32 bytes.
    localparam int PAYLOAD_MAX = 32;
    localparam int RUN_CAP     = 32;
    localparam int LEN_CAP     = (PAYLOAD_MAX < RUN_CAP) ? PAYLOAD_MAX : RUN_CAP;
    localparam int ADDR_W      = $clog2(LEN_CAP);

    // Field widths
    localparam int BYTE_W = 8;
    localparam int LEN_W  = 6;
    localparam int IDX_W  = 5;

    localparam logic [LEN_W-1:0] LEN_CAP_V = LEN_W'(LEN_CAP);
    localparam logic [LEN_W-1:0] LEN_RESET = 6'd16;

    // Frame marker bytes
    localparam logic [BYTE_W-1:0] CH_START = 8'h24;  // '$'
    localparam logic [BYTE_W-1:0] CH_TAG   = 8'h54;  // 'T'
    localparam logic [BYTE_W-1:0] CH_MTYPE = 8'h4D;  // 'M'

    // Parser phases
    typedef enum logic [2:0] {
        PH_START   = 3'd0,
        PH_TAG     = 3'd1,
        PH_TYPE    = 3'd2,
        PH_PAYLOAD = 3'd3,
        PH_CHECK   = 3'd4,
        PH_RUN     = 3'd5
    } t_phase;

endpackage

// ===== rtl/telemetry_frame_parser_unit.sv =====
// Telemetry frame parser: byte-wise frame state machine with payload memory and result run.
//
//  channel   direction  handshake                 payload
//  input     in         i_in_valid / o_in_stall   i_rx_byte
//  output    out        o_out_valid / i_out_stall o_frame_type .. o_last_of_run
//  config    in         i_cfg_wr_en               i_cfg_wr_data
//
// One received byte is taken per cycle while the parser is hunting or reading a frame.
// The checksum byte of an 'M' frame starts a run of N results (N payload bytes), read
// from the payload memory one per cycle unless output stalls; input is stalled for the run.
// A checksum byte is also stalled while a previous result still waits in the output reg.
// Synchronous active-low reset clears the parser state; the payload memory is not cleared.
module telemetry_frame_parser_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // configuration
    input  logic                        i_cfg_wr_en,
    input  logic [tfp_pkg::LEN_W-1:0]   i_cfg_wr_data,
    // input channel
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [tfp_pkg::BYTE_W-1:0]  i_rx_byte,
    // output channel
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [tfp_pkg::BYTE_W-1:0]  o_frame_type,
    output logic                        o_checksum_ok,
    output logic                        o_has_data,
    output logic [tfp_pkg::IDX_W-1:0]   o_byte_index,
    output logic [tfp_pkg::BYTE_W-1:0]  o_payload_byte,
    output logic                        o_last_of_run
);

    tfp_pkg::t_phase r_phase, n_phase;

    logic [tfp_pkg::LEN_W-1:0]  r_cfg_len;
    logic [tfp_pkg::LEN_W-1:0]  r_len;
    logic [tfp_pkg::LEN_W-1:0]  r_byte_count;
    logic [tfp_pkg::BYTE_W-1:0] r_xor;
    logic [tfp_pkg::BYTE_W-1:0] r_type;
    logic                       r_ok;

    // run sequencing
    logic [tfp_pkg::LEN_W-1:0]  r_run_len;
    logic [tfp_pkg::LEN_W-1:0]  r_issue_idx;
    logic                       r_rd_vld;
    logic [tfp_pkg::IDX_W-1:0]  r_rd_idx;
    logic                       r_rd_last;

    // payload memory
    logic [tfp_pkg::BYTE_W-1:0] r_mem [tfp_pkg::LEN_CAP];
    logic [tfp_pkg::BYTE_W-1:0] r_mem_q;

    // output register
    logic                       r_out_valid;
    logic [tfp_pkg::BYTE_W-1:0] r_out_type;
    logic                       r_out_ok;
    logic                       r_out_has_data;
    logic [tfp_pkg::IDX_W-1:0]  r_out_idx;
    logic [tfp_pkg::BYTE_W-1:0] r_out_byte;
    logic                       r_out_last;

    logic                       w_in_stall;
    logic                       w_acc;
    logic                       w_mem_we;
    logic                       w_chk_fire;
    logic                       w_out_free;
    logic                       w_load;
    logic                       w_issue;
    logic                       w_run_done;
    logic                       w_is_m;
    logic [tfp_pkg::LEN_W-1:0]  w_cnt_inc;

    assign w_acc      = i_in_valid && !w_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_load     = r_rd_vld && w_out_free;
    assign w_cnt_inc  = r_byte_count + tfp_pkg::LEN_W'(1);
    assign w_is_m     = (r_type == tfp_pkg::CH_MTYPE);

    // Next phase
    always_comb begin
        n_phase = r_phase;
        case (r_phase)
            tfp_pkg::PH_START: begin
                if (w_acc && i_rx_byte == tfp_pkg::CH_START) n_phase = tfp_pkg::PH_TAG;
            end
            tfp_pkg::PH_TAG: begin
                if (w_acc && i_rx_byte == tfp_pkg::CH_TAG) n_phase = tfp_pkg::PH_TYPE;
            end
            tfp_pkg::PH_TYPE: begin
                if (w_acc) n_phase = tfp_pkg::PH_PAYLOAD;
            end
            tfp_pkg::PH_PAYLOAD: begin
                if (w_acc && w_cnt_inc >= r_len) n_phase = tfp_pkg::PH_CHECK;
            end
            tfp_pkg::PH_CHECK: begin
                if (w_acc) n_phase = w_is_m ? tfp_pkg::PH_RUN : tfp_pkg::PH_START;
            end
            tfp_pkg::PH_RUN: begin
                if (w_run_done) n_phase = tfp_pkg::PH_START;
            end
            default: begin
                n_phase = tfp_pkg::PH_START;
            end
        endcase
    end

    // Phase-driven controls
    always_comb begin
        w_in_stall = 1'b0;
        w_mem_we   = 1'b0;
        w_chk_fire = 1'b0;
        w_issue    = 1'b0;
        w_run_done = 1'b0;
        case (r_phase)
            tfp_pkg::PH_PAYLOAD: begin
                w_mem_we = w_acc;
            end
            tfp_pkg::PH_CHECK: begin
                // the checksum byte needs the output register free
                w_in_stall = r_out_valid;
                w_chk_fire = w_acc;
            end
            tfp_pkg::PH_RUN: begin
                w_in_stall = 1'b1;
                w_issue    = (r_issue_idx != r_run_len) && (!r_rd_vld || w_load);
                w_run_done = (r_issue_idx == r_run_len) && (!r_rd_vld || w_load);
            end
            default: begin
                w_in_stall = 1'b0;
            end
        endcase
    end

    assign o_in_stall = w_in_stall;

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= tfp_pkg::PH_START;
            r_cfg_len    <= tfp_pkg::LEN_RESET;
            r_len        <= '0;
            r_byte_count <= '0;
            r_xor        <= '0;
            r_type       <= '0;
            r_rd_vld     <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            if (i_cfg_wr_en) r_cfg_len <= i_cfg_wr_data;

            // type byte opens the payload
            if (r_phase == tfp_pkg::PH_TYPE && w_acc) begin
                if (i_rx_byte == tfp_pkg::CH_MTYPE) begin
                    r_len <= (r_cfg_len > tfp_pkg::LEN_CAP_V) ? tfp_pkg::LEN_CAP_V : r_cfg_len;
                end
                r_type       <= i_rx_byte;
                r_byte_count <= '0;
                r_xor        <= '0;
            end

            if (w_mem_we) begin
                r_xor        <= r_xor ^ i_rx_byte;
                r_byte_count <= w_cnt_inc;
            end

            // memory read stage
            if (w_issue) r_rd_vld <= 1'b1;
            else if (w_load) r_rd_vld <= 1'b0;

            // output register
            if (w_chk_fire && !w_is_m) r_out_valid <= 1'b1;
            else if (w_load) r_out_valid <= 1'b1;
            else if (!i_out_stall) r_out_valid <= 1'b0;
        end
    end

    // Run bookkeeping and output payload
    always_ff @(posedge i_clk) begin
        if (w_chk_fire) begin
            r_ok        <= (i_rx_byte == r_xor);
            r_run_len   <= r_byte_count;
            r_issue_idx <= '0;
        end else if (w_issue) begin
            r_issue_idx <= r_issue_idx + tfp_pkg::LEN_W'(1);
        end

        if (w_issue) begin
            r_rd_idx  <= r_issue_idx[tfp_pkg::IDX_W-1:0];
            r_rd_last <= (r_issue_idx + tfp_pkg::LEN_W'(1) == r_run_len);
        end

        if (w_chk_fire && !w_is_m) begin
            r_out_type     <= r_type;
            r_out_ok       <= (i_rx_byte == r_xor);
            r_out_has_data <= 1'b0;
            r_out_idx      <= '0;
            r_out_byte     <= '0;
            r_out_last     <= 1'b1;
        end else if (w_load) begin
            r_out_type     <= r_type;
            r_out_ok       <= r_ok;
            r_out_has_data <= 1'b1;
            r_out_idx      <= r_rd_idx;
            r_out_byte     <= r_mem_q;
            r_out_last     <= r_rd_last;
        end
    end

    // Payload memory: written during payload, read during the run
    always_ff @(posedge i_clk) begin
        if (w_mem_we) r_mem[r_byte_count[tfp_pkg::ADDR_W-1:0]] <= i_rx_byte;
        if (w_issue) r_mem_q <= r_mem[r_issue_idx[tfp_pkg::ADDR_W-1:0]];
    end

    assign o_out_valid    = r_out_valid;
    assign o_frame_type   = r_out_type;
    assign o_checksum_ok  = r_out_ok;
    assign o_has_data     = r_out_has_data;
    assign o_byte_index   = r_out_idx;
    assign o_payload_byte = r_out_byte;
    assign o_last_of_run  = r_out_last;

endmodule

// ===== rtl/tfp_checker.sv =====
// Port-level checker for the telemetry frame parser, with its bind.
module tfp_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_in_stall,
    input logic                        o_out_valid,
    input logic                        i_out_stall,
    input logic [tfp_pkg::BYTE_W-1:0]  o_frame_type,
    input logic                        o_checksum_ok,
    input logic                        o_has_data,
    input logic [tfp_pkg::IDX_W-1:0]   o_byte_index,
    input logic [tfp_pkg::BYTE_W-1:0]  o_payload_byte,
    input logic                        o_last_of_run
);

    // a stalled result request holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_frame_type)
            && $stable(o_checksum_ok) && $stable(o_has_data)
            && $stable(o_byte_index) && $stable(o_payload_byte) && $stable(o_last_of_run))
        else $error("stalled result changed");

    // a result without data is a single-result run with zeroed data fields
    a_nodata_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_has_data |-> o_last_of_run && o_byte_index == '0
            && o_payload_byte == '0)
        else $error("malformed no-data result");

    // input stays blocked while a data run is still in progress
    a_run_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_has_data && !o_last_of_run |-> o_in_stall)
        else $error("input open during result run");

    // no result right out of reset
    a_reset_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> !o_out_valid)
        else $error("result present after reset");

endmodule

bind telemetry_frame_parser_unit tfp_checker u_tfp_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_frame_type   (o_frame_type),
    .o_checksum_ok  (o_checksum_ok),
    .o_has_data     (o_has_data),
    .o_byte_index   (o_byte_index),
    .o_payload_byte (o_payload_byte),
    .o_last_of_run  (o_last_of_run)
);

// ===== test/telemetry_result_checker.sv =====
// Result checker for the telemetry frame parser: tracks the frame parser state and compares result runs.
module telemetry_result_checker
    import tfp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration port, observed
    input  logic              i_cfg_wr_en,
    input  logic [LEN_W-1:0]  i_cfg_wr_data,
    // input channel, observed
    input  logic              i_in_valid,
    input  logic              i_in_stall,
    input  logic [BYTE_W-1:0] i_rx_byte,
    // output channel, observed
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  logic [BYTE_W-1:0] i_frame_type,
    input  logic              i_checksum_ok,
    input  logic              i_has_data,
    input  logic [IDX_W-1:0]  i_byte_index,
    input  logic [BYTE_W-1:0] i_payload_byte,
    input  logic              i_last_of_run,
    // status toward the top
    output int                o_fail_count,
    output int                o_pending
);

    typedef struct packed {
        logic [BYTE_W-1:0] frame_type;
        logic              checksum_ok;
        logic              has_data;
        logic [IDX_W-1:0]  byte_index;
        logic [BYTE_W-1:0] payload_byte;
        logic              last_of_run;
    } t_frame_result;

    // results owed by the parser, oldest first
    t_frame_result owed_results[$];

    // shadow of the parser
    t_phase            phase;
    logic [LEN_W-1:0]  m_len_reg;
    logic [LEN_W-1:0]  len_in_use;
    logic [LEN_W-1:0]  byte_cnt;
    logic [BYTE_W-1:0] xor_acc;
    logic [BYTE_W-1:0] cur_type;
    logic [BYTE_W-1:0] payload_mem [LEN_CAP];
    int                fail_cnt = 0;

    // Advance the shadow parser by one accepted byte; a checksum byte queues the run.
    task automatic parse_rx_byte(input logic [BYTE_W-1:0] b);
        t_frame_result res;
        logic          ok;
        int            n;
        case (phase)
            PH_START: begin
                if (b == CH_START) phase = PH_TAG;
            end
            PH_TAG: begin
                // anything but 'T' keeps waiting here
                if (b == CH_TAG) phase = PH_TYPE;
            end
            PH_TYPE: begin
                if (b == CH_MTYPE) len_in_use = (m_len_reg > LEN_CAP_V) ? LEN_CAP_V : m_len_reg;
                cur_type = b;
                byte_cnt = '0;
                xor_acc  = '0;
                phase    = PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
                payload_mem[byte_cnt[ADDR_W-1:0]] = b;
                xor_acc  = xor_acc ^ b;
                byte_cnt = byte_cnt + LEN_W'(1);
                // zero length still takes one byte
                if (byte_cnt >= len_in_use) phase = PH_CHECK;
            end
            PH_CHECK: begin
                phase = PH_START;
                ok    = (b == xor_acc);
                if (cur_type == CH_MTYPE) begin
                    // byte_cnt is 1..LEN_CAP here
                    n = int'(byte_cnt);
                    for (int k = 0; k < n; k++) begin
                        res.frame_type   = cur_type;
                        res.checksum_ok  = ok;
                        res.has_data     = 1'b1;
                        res.byte_index   = IDX_W'(k);
                        res.payload_byte = payload_mem[k];
                        res.last_of_run  = (k == n - 1);
                        owed_results.push_back(res);
                    end
                end else begin
                    res             = '0;
                    res.frame_type  = cur_type;
                    res.checksum_ok = ok;
                    res.last_of_run = 1'b1;
                    owed_results.push_back(res);
                end
            end
            default: begin
                phase = PH_START;
            end
        endcase
    endtask

    // Compare one accepted result with the oldest owed one.
    task automatic check_result(input t_frame_result got);
        t_frame_result want;
        if (owed_results.size() == 0) begin
            fail_cnt++;
            if (fail_cnt <= 10)
                $display("unexpected result: type=%h ok=%b data=%b idx=%0d byte=%h last=%b",
                         got.frame_type, got.checksum_ok, got.has_data, got.byte_index,
                         got.payload_byte, got.last_of_run);
            return;
        end
        want = owed_results.pop_front();
        if (want !== got) begin
            fail_cnt++;
            if (fail_cnt <= 10) begin
                $display("result mismatch: expected type=%h ok=%b data=%b idx=%0d byte=%h last=%b",
                         want.frame_type, want.checksum_ok, want.has_data, want.byte_index,
                         want.payload_byte, want.last_of_run);
                $display("                 got      type=%h ok=%b data=%b idx=%0d byte=%h last=%b",
                         got.frame_type, got.checksum_ok, got.has_data, got.byte_index,
                         got.payload_byte, got.last_of_run);
            end
        end
    endtask

    // Watch all three ports at each edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            phase      = PH_START;
            m_len_reg  = LEN_RESET;
            len_in_use = '0;
            byte_cnt   = '0;
            xor_acc    = '0;
            cur_type   = '0;
            owed_results.delete();
        end else begin
            if (i_out_valid && !i_out_stall)
                check_result(t_frame_result'({i_frame_type, i_checksum_ok, i_has_data,
                                              i_byte_index, i_payload_byte, i_last_of_run}));
            // a byte taken at the write edge still sees the old length
            if (i_in_valid && !i_in_stall) parse_rx_byte(i_rx_byte);
            if (i_cfg_wr_en) m_len_reg = i_cfg_wr_data;
        end
        o_pending    <= owed_results.size();
        o_fail_count <= fail_cnt;
    end

endmodule

// ===== test/testbench.sv =====
// Top of the frame parser testbench: clock, reset, byte stimulus, output stalls and verdict.
module testbench;
    import tfp_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int LATENCY_WAIT = 40;

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              i_cfg_wr_en   = 1'b0;
    logic [LEN_W-1:0]  i_cfg_wr_data = '0;
    logic              i_in_valid    = 1'b0;
    logic              o_in_stall;
    logic [BYTE_W-1:0] i_rx_byte     = '0;
    logic              o_out_valid;
    logic              i_out_stall   = 1'b0;
    logic [BYTE_W-1:0] o_frame_type;
    logic              o_checksum_ok;
    logic              o_has_data;
    logic [IDX_W-1:0]  o_byte_index;
    logic [BYTE_W-1:0] o_payload_byte;
    logic              o_last_of_run;

    int fail_count;
    int pending;
    int cycle_cnt      = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    // sender's view of the register and of the length the parser will use
    logic [LEN_W-1:0] cfg_len = LEN_RESET;
    logic [LEN_W-1:0] len_now = '0;

    telemetry_frame_parser_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_rx_byte      (i_rx_byte),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_frame_type   (o_frame_type),
        .o_checksum_ok  (o_checksum_ok),
        .o_has_data     (o_has_data),
        .o_byte_index   (o_byte_index),
        .o_payload_byte (o_payload_byte),
        .o_last_of_run  (o_last_of_run)
    );

    telemetry_result_checker checker_i (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_rx_byte      (i_rx_byte),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_frame_type   (o_frame_type),
        .i_checksum_ok  (o_checksum_ok),
        .i_has_data     (o_has_data),
        .i_byte_index   (o_byte_index),
        .i_payload_byte (o_payload_byte),
        .i_last_of_run  (o_last_of_run),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    always #1 i_clk = ~i_clk;

    // random output stalls
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    // Offer one byte, with random idle cycles first; returns at the accepting edge.
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_rx_byte  <= b;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    // Length register write, only once every owed result is out and the run has drained.
    task automatic write_length(input logic [LEN_W-1:0] v);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY_WAIT) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        cfg_len = v;
    endtask

    // Whole frame with random payload; the checksum is right unless bad_check.
    task automatic send_frame(input logic [BYTE_W-1:0] ftype, input bit bad_check,
                              output int n_sent);
        int                nbytes;
        logic [BYTE_W-1:0] b;
        logic [BYTE_W-1:0] acc;
        send_byte(CH_START);
        send_byte(CH_TAG);
        send_byte(ftype);
        if (ftype == CH_MTYPE) len_now = (cfg_len > LEN_CAP_V) ? LEN_CAP_V : cfg_len;
        nbytes = (len_now == 0) ? 1 : int'(len_now);
        acc = '0;
        for (int k = 0; k < nbytes; k++) begin
            b   = BYTE_W'($urandom_range(255));
            acc = acc ^ b;
            send_byte(b);
        end
        if (bad_check) acc = acc ^ BYTE_W'($urandom_range(1, 255));
        send_byte(acc);
        n_sent = nbytes + 4;
    endtask

    // Mostly well-formed frames, with stray bytes, false starts and length changes.
    task automatic random_phase(input int snd_pct, input int rcv_pct,
                                input logic [LEN_W-1:0] first_len, input int n_items);
        int                sent;
        int                n;
        int                pick;
        logic [BYTE_W-1:0] b;
        logic [BYTE_W-1:0] ftype;
        logic [LEN_W-1:0]  next_len;
        send_idle_pct  = snd_pct;
        recv_stall_pct = rcv_pct;
        write_length(first_len);
        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(9);
            if (pick < 2) begin
                // stray bytes, never 'T', so the parser stays hunting or waiting for 'T'
                if (pick == 1) begin
                    send_byte(CH_START);
                    sent++;
                end
                n = $urandom_range(1, 3);
                repeat (n) begin
                    b = BYTE_W'($urandom_range(255));
                    if (b == CH_TAG) b = ~b;
                    send_byte(b);
                end
                sent += n;
            end else begin
                if ($urandom_range(99) < 30) begin
                    // small lengths mostly, extremes now and then
                    case ($urandom_range(9))
                        0:       next_len = '0;
                        1:       next_len = 6'd1;
                        2:       next_len = 6'd32;
                        3:       next_len = 6'd63;
                        4:       next_len = LEN_W'($urandom_range(33, 63));
                        default: next_len = LEN_W'($urandom_range(2, 8));
                    endcase
                    write_length(next_len);
                end
                ftype = ($urandom_range(99) < 65) ? CH_MTYPE : BYTE_W'($urandom_range(255));
                send_frame(ftype, ($urandom_range(99) < 25), n);
                sent += n;
            end
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // stray bytes during the hunt
        send_byte(8'h00);
        send_byte(8'hFF);
        // '$', a non-'T' byte that keeps waiting, then a non-'M' frame at zero length
        send_byte(CH_START);
        send_byte(8'hAA);
        send_byte(CH_TAG);
        send_byte(8'h41);
        send_byte(8'hFF);
        send_byte(8'hFF);
        // one-byte 'M' frame, good checksum
        write_length(6'd1);
        send_byte(CH_START);
        send_byte(CH_TAG);
        send_byte(CH_MTYPE);
        send_byte(8'h5A);
        send_byte(8'h5A);
        // zero-length 'M' frame still reads one byte; bad checksum
        write_length('0);
        send_byte(CH_START);
        send_byte(CH_TAG);
        send_byte(CH_MTYPE);
        send_byte(8'h80);
        send_byte(8'h7F);
        // length write in mid-frame must not change the frame being read
        write_length(6'd2);
        send_byte(CH_START);
        send_byte(CH_TAG);
        send_byte(CH_MTYPE);
        send_byte(8'h01);
        write_length(6'd5);
        send_byte(8'hFE);
        send_byte(8'hFF);
        len_now = 6'd2;

        random_phase(6, 87, 6'd63, 85);
        random_phase(87, 6, 6'd33, 85);
        random_phase(0, 0, 6'd4, 85);

        // drain
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY_WAIT) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/tfp_pkg.sv
rtl/telemetry_frame_parser_unit.sv
rtl/tfp_checker.sv
test/telemetry_result_checker.sv
test/testbench.sv
